[rtl/prq_pkg.sv]
`default_nettype none

package prq_pkg;

	// field widths fixed by the command format
	localparam int unsigned THREAD_W = 6;
	localparam int unsigned PRIO_W   = 6;

	typedef enum logic [1:0] {
		CMD_ADD_HEAD = 2'd0,
		CMD_ADD_TAIL = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_CHOOSE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NOT_PERMITTED = 2'd1,
		ST_NOT_FOUND     = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                  command;
		logic [THREAD_W-1:0]   thread_id;
		logic [PRIO_W-1:0]     priority_req;
		logic                  ready_req;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic                  chosen_valid;
		logic [THREAD_W-1:0]   chosen_thread;
		logic                  top_valid;
		logic [PRIO_W-1:0]     top_priority;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/prq_top_enc.sv]
`default_nettype none

module prq_top_enc #(
	parameter int unsigned WIDTH = 64
) (
	input  wire logic [WIDTH-1:0]         bitmap,
	output logic                          found,
	output logic [$clog2(WIDTH)-1:0]      index
);

	// scan upwards so the highest set bit wins
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (bitmap[i]) begin
				found = 1'b1;
				index = ($clog2(WIDTH))'(i);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/priority_ready_queue.sv]
`default_nettype none

// An accepted item is registered in req_s1; its result is then registered in rsp_q, marked by done.
// Throughput: one item per cycle; busy is set by reset and cleared by the following clock edge.
// The single pass through the link arrays and the bitmap encoder sets the cycle.
// Reset (arst_n low) empties every list, clears the bitmap and invalidates the top.
// The receiver cannot stall: each result shows for exactly one cycle.
module priority_ready_queue #(
	parameter int unsigned NUM_PRIORITIES = 64,
	parameter int unsigned NUM_THREADS    = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire prq_pkg::req_t  req,
	output logic                done,
	output prq_pkg::rsp_t       rsp
);

	localparam int unsigned TIW = $clog2(NUM_THREADS);
	localparam int unsigned PIW = $clog2(NUM_PRIORITIES);
	localparam int unsigned LW  = $clog2(NUM_THREADS + 1);
	localparam logic [LW-1:0] NIL = LW'(NUM_THREADS);

	// input stage
	logic           busy_q;
	logic           valid_s1;
	prq_pkg::req_t  req_s1;

	// queue state
	logic [NUM_PRIORITIES-1:0] bitmap_q, bitmap_d;
	logic                      top_valid_q, top_valid_d;
	logic [PIW-1:0]            top_q, top_d;
	logic [LW-1:0]             head_q [NUM_PRIORITIES];
	logic [LW-1:0]             head_d [NUM_PRIORITIES];
	logic [LW-1:0]             tail_q [NUM_PRIORITIES];
	logic [LW-1:0]             tail_d [NUM_PRIORITIES];
	logic [LW-1:0]             next_q [NUM_THREADS];
	logic [LW-1:0]             next_d [NUM_THREADS];
	logic [LW-1:0]             prev_q [NUM_THREADS];
	logic [LW-1:0]             prev_d [NUM_THREADS];
	logic [NUM_THREADS-1:0]    linked_q, linked_d;
	logic [PIW-1:0]            level_q [NUM_THREADS];
	logic [PIW-1:0]            level_d [NUM_THREADS];

	// working values
	logic [TIW-1:0]            t;
	logic [PIW-1:0]            p;
	logic [LW-1:0]             t_link;
	logic                      ranged;
	logic [LW-1:0]             h, tl, n, v;
	logic [PIW-1:0]            p0;
	logic [NUM_PRIORITIES-1:0] bitmap_clr;
	logic                      enc_found;
	logic [PIW-1:0]            enc_index;
	prq_pkg::rsp_t             rsp_d;
	logic                      done_q;
	prq_pkg::rsp_t             rsp_q;

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// set busy in reset and clear it at the next clock, then take an item every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_s1 <= req;
		end
	end

	// find the new top with the given level's bit dropped
	assign t          = TIW'(req_s1.thread_id);
	assign p          = PIW'(req_s1.priority_req);
	assign t_link     = LW'(t);
	assign bitmap_clr = bitmap_q & ~(NUM_PRIORITIES'(1) << p);

	prq_top_enc #(
		.WIDTH (NUM_PRIORITIES)
	) u_top_enc (
		.bitmap (bitmap_clr),
		.found  (enc_found),
		.index  (enc_index)
	);

	// decode the command and update the lists
	always_comb begin
		bitmap_d    = bitmap_q;
		top_valid_d = top_valid_q;
		top_d       = top_q;
		head_d      = head_q;
		tail_d      = tail_q;
		next_d      = next_q;
		prev_d      = prev_q;
		linked_d    = linked_q;
		level_d     = level_q;
		rsp_d       = '0;
		ranged      = (int'(req_s1.thread_id) < NUM_THREADS) &&
		              (int'(req_s1.priority_req) < NUM_PRIORITIES);
		h           = head_q[p];
		tl          = tail_q[p];
		p0          = level_q[t];
		n           = next_q[t];
		v           = prev_q[t];

		unique case (req_s1.command)
			prq_pkg::CMD_ADD_HEAD, prq_pkg::CMD_ADD_TAIL: begin
				if (!req_s1.ready_req || !ranged) begin
					rsp_d.status = prq_pkg::ST_NOT_PERMITTED;
				end else if (!linked_q[t]) begin
					if (h == NIL) begin
						next_d[t] = NIL;
						prev_d[t] = NIL;
						head_d[p] = t_link;
						tail_d[p] = t_link;
					end else if (req_s1.command == prq_pkg::CMD_ADD_HEAD) begin
						next_d[t]           = h;
						prev_d[t]           = NIL;
						prev_d[h[TIW-1:0]]  = t_link;
						head_d[p]           = t_link;
					end else begin
						prev_d[t]           = tl;
						next_d[t]           = NIL;
						next_d[tl[TIW-1:0]] = t_link;
						tail_d[p]           = t_link;
					end
					linked_d[t] = 1'b1;
					level_d[t]  = p;
					if (!bitmap_q[p]) begin
						bitmap_d[p] = 1'b1;
						if (!top_valid_q || top_q < p) begin
							top_valid_d = 1'b1;
							top_d       = p;
						end
					end
				end
			end
			prq_pkg::CMD_REMOVE: begin
				if (!req_s1.ready_req || !ranged) begin
					rsp_d.status = prq_pkg::ST_NOT_FOUND;
				end else begin
					if (linked_q[t]) begin
						if (v == NIL) begin
							head_d[p0] = n;
						end else begin
							next_d[v[TIW-1:0]] = n;
						end
						if (n == NIL) begin
							tail_d[p0] = v;
						end else begin
							prev_d[n[TIW-1:0]] = v;
						end
						linked_d[t] = 1'b0;
					end
					if (head_d[p] == NIL) begin
						bitmap_d    = bitmap_clr;
						top_valid_d = enc_found;
						top_d       = enc_index;
					end
				end
			end
			prq_pkg::CMD_CHOOSE: begin
				if (top_valid_q && head_q[top_q] != NIL) begin
					rsp_d.chosen_valid  = 1'b1;
					rsp_d.chosen_thread = prq_pkg::THREAD_W'(head_q[top_q]);
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase

		rsp_d.top_valid    = top_valid_d;
		rsp_d.top_priority = top_valid_d ? prq_pkg::PRIO_W'(top_d) : '0;
	end

	// commit list heads, tails, linked flags, bitmap and top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q    <= '0;
			top_valid_q <= 1'b0;
			top_q       <= '0;
			linked_q    <= '0;
			done_q      <= 1'b0;
			for (int i = 0; i < NUM_PRIORITIES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				bitmap_q    <= bitmap_d;
				top_valid_q <= top_valid_d;
				top_q       <= top_d;
				linked_q    <= linked_d;
				head_q      <= head_d;
				tail_q      <= tail_d;
			end
		end
	end

	// commit per-thread links; read only while the thread is linked
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			next_q  <= next_d;
			prev_q  <= prev_d;
			level_q <= level_d;
			rsp_q   <= rsp_d;
		end
	end

`ifndef ASSERT_OFF
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("accepted item gave no result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("result without an accepted item");

	a_top_marked: assert property (@(posedge clk) disable iff (!arst_n)
		top_valid_q |-> bitmap_q[top_q])
		else $error("top level not marked in bitmap");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		!top_valid_q |-> (bitmap_q == '0))
		else $error("bitmap marked while top invalid");

	a_chosen_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.chosen_valid) |-> rsp_q.top_valid)
		else $error("thread chosen without a valid top");
`endif

endmodule

`default_nettype wire

[tb/priority_ready_queue_test.sv]
`timescale 1ns / 1ps

module priority_ready_queue_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 950;
	localparam logic [6:0] NIL = 7'd64;

	typedef struct {
		prq_pkg::req_t req;
		int            gap;
		bit            drain;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	prq_pkg::req_t req = '0;
	logic busy;
	logic done;
	prq_pkg::rsp_t rsp;

	priority_ready_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// ready queue as the testbench sees it
	logic [6:0] rq_head [0:63];
	logic [6:0] rq_tail [0:63];
	logic [6:0] rq_next [0:63];
	logic [6:0] rq_prev [0:63];
	logic [5:0] rq_level [0:63];
	bit         rq_linked [0:63];
	bit         rq_bitmap [0:63];
	bit         rq_top_ok;
	logic [5:0] rq_top;

	// stimulus generator's own view of which threads are queued
	bit         gen_linked [0:63];
	int         gen_prio [0:63];
	bit         no_gaps;
	bit         drain_next;

	pend_t         pending [$];
	prq_pkg::rsp_t expected_rsp [$];
	int    items_taken = 0;
	int    results_seen = 0;
	int    gap_left = 0;
	int    errors = 0;
	int    cycles = 0;
	int    n_chosen = 0;
	int    n_refused = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the queue image and return its response.
	function automatic prq_pkg::rsp_t apply_request(prq_pkg::req_t r);
		prq_pkg::rsp_t o;
		logic [6:0] t;
		logic [6:0] p;
		logic [6:0] n;
		logic [6:0] v;
		logic [5:0] lv;
		o = '0;
		o.status = prq_pkg::ST_OK;
		t = {1'b0, r.thread_id};
		p = {1'b0, r.priority_req};
		case (r.command)
			prq_pkg::CMD_ADD_HEAD, prq_pkg::CMD_ADD_TAIL: begin
				if (!r.ready_req) begin
					o.status = prq_pkg::ST_NOT_PERMITTED;
				end else if (!rq_linked[t[5:0]]) begin
					if (rq_head[p[5:0]] == NIL) begin
						rq_next[t[5:0]] = NIL;
						rq_prev[t[5:0]] = NIL;
						rq_head[p[5:0]] = t;
						rq_tail[p[5:0]] = t;
					end else if (r.command == prq_pkg::CMD_ADD_HEAD) begin
						rq_next[t[5:0]] = rq_head[p[5:0]];
						rq_prev[t[5:0]] = NIL;
						rq_prev[rq_head[p[5:0]][5:0]] = t;
						rq_head[p[5:0]] = t;
					end else begin
						rq_prev[t[5:0]] = rq_tail[p[5:0]];
						rq_next[t[5:0]] = NIL;
						rq_next[rq_tail[p[5:0]][5:0]] = t;
						rq_tail[p[5:0]] = t;
					end
					rq_linked[t[5:0]] = 1'b1;
					rq_level[t[5:0]] = p[5:0];
					// raise the top only when the level was empty
					if (!rq_bitmap[p[5:0]]) begin
						rq_bitmap[p[5:0]] = 1'b1;
						if (!rq_top_ok || rq_top < p[5:0]) begin
							rq_top_ok = 1'b1;
							rq_top = p[5:0];
						end
					end
				end
			end
			prq_pkg::CMD_REMOVE: begin
				if (!r.ready_req) begin
					o.status = prq_pkg::ST_NOT_FOUND;
				end else begin
					// unlink from the list the thread really sits in
					if (rq_linked[t[5:0]]) begin
						lv = rq_level[t[5:0]];
						n = rq_next[t[5:0]];
						v = rq_prev[t[5:0]];
						if (v == NIL)
							rq_head[lv] = n;
						else
							rq_next[v[5:0]] = n;
						if (n == NIL)
							rq_tail[lv] = v;
						else
							rq_prev[n[5:0]] = v;
						rq_linked[t[5:0]] = 1'b0;
					end
					// the emptiness test looks at the requested level
					if (rq_head[p[5:0]] == NIL) begin
						rq_bitmap[p[5:0]] = 1'b0;
						rq_top_ok = 1'b0;
						rq_top = '0;
						for (int k = 0; k < 64; k++) begin
							if (rq_bitmap[k]) begin
								rq_top_ok = 1'b1;
								rq_top = k[5:0];
							end
						end
					end
				end
			end
			prq_pkg::CMD_CHOOSE: begin
				if (rq_top_ok && rq_head[rq_top] != NIL) begin
					o.chosen_valid = 1'b1;
					o.chosen_thread = rq_head[rq_top][5:0];
				end
			end
		endcase
		o.top_valid = rq_top_ok;
		o.top_priority = rq_top_ok ? rq_top : '0;
		return o;
	endfunction

	// Queue one item for the driver, with a random gap after it.
	task automatic queue_item(prq_pkg::cmd_t c, int t, int p, bit rdy);
		pend_t it;
		int r;
		it.req.command = c;
		it.req.thread_id = t[5:0];
		it.req.priority_req = p[5:0];
		it.req.ready_req = rdy;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70)
			it.gap = 0;
		else if (r < 93)
			it.gap = $urandom_range(1, 3);
		else
			it.gap = $urandom_range(8, 40);
		it.drain = drain_next;
		drain_next = 1'b0;
		pending.push_back(it);
		// keep the generator's view in step
		if (rdy && (c == prq_pkg::CMD_ADD_HEAD || c == prq_pkg::CMD_ADD_TAIL) &&
			!gen_linked[t]) begin
			gen_linked[t] = 1'b1;
			gen_prio[t] = p;
		end else if (rdy && c == prq_pkg::CMD_REMOVE) begin
			gen_linked[t] = 1'b0;
		end
	endtask

	// Driver: launch items, predict on acceptance.
	always @(posedge clk) begin : drive
		pend_t nxt_item;
		bit taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				expected_rsp.push_back(apply_request(req));
				items_taken <= items_taken + 1;
			end
			if (start && !taken) begin
				// hold the item until it is taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending.size() != 0 &&
				!(pending[0].drain && items_taken + taken != results_seen)) begin
				nxt_item = pending.pop_front();
				req <= nxt_item.req;
				start <= 1'b1;
				gap_left <= nxt_item.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check each result against the oldest expectation.
	always @(posedge clk) begin : watch
		prq_pkg::rsp_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_rsp.size() == 0) begin
				$error("unexpected result: status %0d chosen %0d/%0d top %0d/%0d",
					rsp.status, rsp.chosen_valid, rsp.chosen_thread,
					rsp.top_valid, rsp.top_priority);
				errors <= errors + 1;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors <= errors + 1;
				end
				if (rsp.chosen_valid != want.chosen_valid) begin
					$error("chosen_valid: expected %0d, got %0d",
						want.chosen_valid, rsp.chosen_valid);
					errors <= errors + 1;
				end
				if (rsp.chosen_thread != want.chosen_thread) begin
					$error("chosen_thread: expected %0d, got %0d",
						want.chosen_thread, rsp.chosen_thread);
					errors <= errors + 1;
				end
				if (rsp.top_valid != want.top_valid) begin
					$error("top_valid: expected %0d, got %0d", want.top_valid, rsp.top_valid);
					errors <= errors + 1;
				end
				if (rsp.top_priority != want.top_priority) begin
					$error("top_priority: expected %0d, got %0d",
						want.top_priority, rsp.top_priority);
					errors <= errors + 1;
				end
				if (want.chosen_valid)
					n_chosen <= n_chosen + 1;
				if (want.status != prq_pkg::ST_OK)
					n_refused <= n_refused + 1;
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL priority_ready_queue");
			$finish;
		end
	end

	initial begin : stimulus
		int sel;
		int t;
		int p;
		int base;
		bit rdy;
		prq_pkg::cmd_t c;
		for (int i = 0; i < 64; i++) begin
			rq_head[i] = NIL;
			rq_tail[i] = NIL;
			rq_next[i] = NIL;
			rq_prev[i] = NIL;
			rq_level[i] = '0;
			rq_linked[i] = 1'b0;
			rq_bitmap[i] = 1'b0;
			gen_linked[i] = 1'b0;
			gen_prio[i] = 0;
		end
		rq_top_ok = 1'b0;
		rq_top = '0;
		no_gaps = 1'b0;
		drain_next = 1'b0;

		// directed: edges of the fields and the odd cases of the queue
		queue_item(prq_pkg::CMD_CHOOSE, 0, 0, 1'b0);       // choose on an empty queue
		queue_item(prq_pkg::CMD_ADD_HEAD, 0, 0, 1'b1);
		queue_item(prq_pkg::CMD_ADD_TAIL, 63, 63, 1'b1);
		queue_item(prq_pkg::CMD_ADD_TAIL, 1, 63, 1'b1);
		queue_item(prq_pkg::CMD_ADD_HEAD, 2, 63, 1'b1);
		queue_item(prq_pkg::CMD_CHOOSE, 63, 63, 1'b1);
		queue_item(prq_pkg::CMD_ADD_HEAD, 3, 5, 1'b0);     // add while not ready
		queue_item(prq_pkg::CMD_ADD_TAIL, 63, 10, 1'b1);   // add of a queued thread
		queue_item(prq_pkg::CMD_REMOVE, 4, 20, 1'b0);      // remove while not ready
		queue_item(prq_pkg::CMD_REMOVE, 2, 63, 1'b1);      // drop the head
		queue_item(prq_pkg::CMD_CHOOSE, 0, 0, 1'b0);
		queue_item(prq_pkg::CMD_REMOVE, 1, 63, 1'b1);      // drop the tail
		queue_item(prq_pkg::CMD_REMOVE, 5, 40, 1'b1);      // remove of an unqueued thread
		queue_item(prq_pkg::CMD_REMOVE, 63, 10, 1'b1);     // remove at the wrong level
		queue_item(prq_pkg::CMD_CHOOSE, 0, 0, 1'b1);       // top valid but its list empty
		queue_item(prq_pkg::CMD_REMOVE, 6, 63, 1'b1);      // clears the stale top
		queue_item(prq_pkg::CMD_CHOOSE, 0, 0, 1'b0);
		queue_item(prq_pkg::CMD_ADD_HEAD, 42, 0, 1'b1);
		queue_item(prq_pkg::CMD_REMOVE, 0, 0, 1'b1);
		queue_item(prq_pkg::CMD_ADD_TAIL, 21, 0, 1'b1);
		queue_item(prq_pkg::CMD_ADD_TAIL, 22, 0, 1'b1);
		queue_item(prq_pkg::CMD_REMOVE, 21, 0, 1'b1);      // drop from the middle
		queue_item(prq_pkg::CMD_CHOOSE, 0, 0, 1'b0);
		queue_item(prq_pkg::CMD_REMOVE, 42, 0, 1'b1);
		queue_item(prq_pkg::CMD_REMOVE, 22, 0, 1'b1);

		// random: mostly sensible add/remove/choose traffic, some noise
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			no_gaps = (k % 150) < 40;
			if (k == 0 || k == 400)
				drain_next = 1'b1;
			sel = $urandom_range(0, 99);
			rdy = $urandom_range(0, 19) != 0;
			if ($urandom_range(0, 1))
				p = $urandom_range(0, 63);
			else if ($urandom_range(0, 1))
				p = $urandom_range(0, 3);
			else
				p = $urandom_range(60, 63);
			if (sel < 35) begin
				// add, preferring a thread that is not queued yet
				t = $urandom_range(0, 63);
				for (int tries = 0; tries < 4 && gen_linked[t]; tries++)
					t = $urandom_range(0, 63);
				c = $urandom_range(0, 1) ? prq_pkg::CMD_ADD_HEAD : prq_pkg::CMD_ADD_TAIL;
				queue_item(c, t, p, rdy);
			end else if (sel < 65) begin
				// remove, mostly a queued thread at its own level
				t = $urandom_range(0, 63);
				if ($urandom_range(0, 99) < 85) begin
					base = t;
					for (int j = 0; j < 64; j++) begin
						if (!gen_linked[t])
							t = (base + j) % 64;
					end
					if (gen_linked[t] && $urandom_range(0, 9) != 0)
						p = gen_prio[t];
				end
				queue_item(prq_pkg::CMD_REMOVE, t, p, rdy);
			end else if (sel < 90) begin
				queue_item(prq_pkg::CMD_CHOOSE, $urandom_range(0, 63), p,
					$urandom_range(0, 1) != 0);
			end else begin
				c = prq_pkg::cmd_t'($urandom_range(0, 3));
				queue_item(c, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1) != 0);
			end
		end

		// reset once, then let the driver run
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last item and its result
		@(negedge clk);
		while (pending.size() != 0 || start || items_taken != results_seen)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d items: %0d choose hits, %0d refused adds/removes.",
			items_taken, n_chosen, n_refused);
		$display("Covered head/tail/middle unlink, stale top, and a full drain pause.");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("PASS priority_ready_queue");
		end else begin
			$display("FAIL priority_ready_queue");
		end
		$finish;
	end

endmodule
